// ----- rtl/ngd_pkg.sv -----
`default_nettype none
package ngd_pkg;

  localparam int MAX_DIM_DEFAULT = 4096;

  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 3;
  localparam int PIX_W     = 8;
  localparam int POS_W     = 12;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE    = 3'd4;

  localparam logic [CFG_W-1:0] RST_SOURCE_WIDTH  = 13'd320;
  localparam logic [CFG_W-1:0] RST_SOURCE_HEIGHT = 13'd240;
  localparam logic [CFG_W-1:0] RST_TARGET_WIDTH  = 13'd96;
  localparam logic [CFG_W-1:0] RST_TARGET_HEIGHT = 13'd96;
  localparam logic             RST_COLOR_MODE    = 1'b1;

  localparam logic COLOR_GRAY = 1'b0;
  localparam logic COLOR_RGB  = 1'b1;

  // Luma weights in 16-bit fixed point; they sum to exactly 65536.
  localparam int LUMA_ACC_W = 24;
  localparam logic [15:0] LUMA_COEF_R = 16'd19595;
  localparam logic [15:0] LUMA_COEF_G = 16'd38470;
  localparam logic [15:0] LUMA_COEF_B = 16'd7471;

endpackage
`default_nettype wire

// ----- rtl/nearest_neighbor_gray_downscaler.sv -----
`default_nettype none
// Channel | Direction | Accepted when          | Payload
// in_     | in        | in_tvalid & in_tready  | tdata: red, green, blue
// out_    | out       | out_tvalid & out_tready| tdata: luma, out_col, out_row; tlast
// cfg_    | in        | cfg_valid & cfg_ready  | cfg_index, cfg_data
//
// One item per clock unless a stall blocks a kept pixel; taken, it is on out_ next cycle.
// The hit decision and the position counters live in one stage before the output register.
// Items that are dropped are taken even while the output register holds a stalled result.
// Reset (synchronous, rst_n low) restores the default sizes and restarts the frame.
// Any write to a known register also restarts the frame; cfg_ready is always high.
module nearest_neighbor_gray_downscaler #(
  parameter int MAX_DIM = ngd_pkg::MAX_DIM_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [ngd_pkg::IN_DATA_W-1:0]     in_tdata,   // red, green, blue
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic      [ngd_pkg::OUT_DATA_W-1:0]    out_tdata,  // luma, out_col, out_row
  output logic                                   out_tlast,  // frame_end
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [ngd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ngd_pkg::CFG_W-1:0]         cfg_data
);

  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int SRC_W  = $clog2(MAX_DIM);
  localparam int SUM_W  = 2 * DIM_W;
  localparam int WIDE_W = (DIM_W > ngd_pkg::CFG_W) ? DIM_W : ngd_pkg::CFG_W;
  localparam logic [WIDE_W-1:0] MAX_WIDE = WIDE_W'(MAX_DIM);

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [ngd_pkg::CFG_W-1:0] raw);
    logic [WIDE_W-1:0] w;
    w = WIDE_W'(raw);
    if (w == '0) begin
      w = WIDE_W'(1);
    end else if (w > MAX_WIDE) begin
      w = MAX_WIDE;
    end
    return DIM_W'(w);
  endfunction

  logic [ngd_pkg::CFG_W-1:0] src_w_r, src_h_r, tgt_w_r, tgt_h_r;
  logic                      color_mode_r;

  logic [SRC_W-1:0] src_col_r, src_col_nxt, src_row_r, src_row_nxt;
  logic [DIM_W-1:0] dst_col_r, dst_col_nxt, dst_row_r, dst_row_nxt;
  logic [SUM_W-1:0] col_src_sum_r, col_src_sum_nxt, col_dst_sum_r, col_dst_sum_nxt;
  logic [SUM_W-1:0] row_src_sum_r, row_src_sum_nxt, row_dst_sum_r, row_dst_sum_nxt;

  logic                         out_tvalid_r;
  logic [ngd_pkg::OUT_DATA_W-1:0] out_tdata_r;
  logic                         out_tlast_r;

  logic [DIM_W-1:0] sw, sh, tw, th, tw_raw, th_raw;
  logic [DIM_W-1:0] src_col_inc, src_row_inc, dst_col_inc, dst_row_inc;
  logic             col_hit, row_hit, hit, row_end, frame_wrap, frame_end;
  logic             in_acc, cfg_acc, cfg_known;
  logic [ngd_pkg::PIX_W-1:0] luma;

  assign sw     = clamp_dim(src_w_r);
  assign sh     = clamp_dim(src_h_r);
  assign tw_raw = clamp_dim(tgt_w_r);
  assign th_raw = clamp_dim(tgt_h_r);
  assign tw     = (tw_raw > sw) ? sw : tw_raw;
  assign th     = (th_raw > sh) ? sh : th_raw;

  assign src_col_inc = DIM_W'(src_col_r) + DIM_W'(1);
  assign src_row_inc = DIM_W'(src_row_r) + DIM_W'(1);
  assign dst_col_inc = dst_col_r + DIM_W'(1);
  assign dst_row_inc = dst_row_r + DIM_W'(1);

  assign col_hit    = (dst_col_r < tw) && (col_dst_sum_r < col_src_sum_r + SUM_W'(tw));
  assign row_hit    = (dst_row_r < th) && (row_dst_sum_r < row_src_sum_r + SUM_W'(th));
  assign hit        = col_hit && row_hit;
  assign row_end    = (src_col_inc >= sw);
  assign frame_wrap = row_end && (src_row_inc >= sh);
  assign frame_end  = (dst_col_inc == tw) && (dst_row_inc == th);

  assign in_tready = !out_tvalid_r || out_tready || !hit;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;

  always_comb begin
    unique case (cfg_index) inside
      ngd_pkg::REG_SOURCE_WIDTH, ngd_pkg::REG_SOURCE_HEIGHT, ngd_pkg::REG_TARGET_WIDTH,
      ngd_pkg::REG_TARGET_HEIGHT, ngd_pkg::REG_COLOR_MODE: cfg_known = 1'b1;
      default: cfg_known = 1'b0;
    endcase
  end

  ngd_luma u_luma (
    .red        (in_tdata[7:0]),
    .green      (in_tdata[15:8]),
    .blue       (in_tdata[23:16]),
    .color_mode (color_mode_r),
    .luma       (luma)
  );

  always_comb begin
    src_col_nxt     = src_col_r;
    src_row_nxt     = src_row_r;
    dst_col_nxt     = dst_col_r;
    dst_row_nxt     = dst_row_r;
    col_src_sum_nxt = col_src_sum_r;
    col_dst_sum_nxt = col_dst_sum_r;
    row_src_sum_nxt = row_src_sum_r;
    row_dst_sum_nxt = row_dst_sum_r;
    if (cfg_acc && cfg_known) begin
      src_col_nxt     = '0;
      src_row_nxt     = '0;
      dst_col_nxt     = '0;
      dst_row_nxt     = '0;
      col_src_sum_nxt = '0;
      col_dst_sum_nxt = '0;
      row_src_sum_nxt = '0;
      row_dst_sum_nxt = '0;
    end else if (in_acc) begin
      if (hit) begin
        dst_col_nxt     = dst_col_inc;
        col_dst_sum_nxt = col_dst_sum_r + SUM_W'(sw);
      end
      if (!row_end) begin
        src_col_nxt     = SRC_W'(src_col_inc);
        col_src_sum_nxt = col_src_sum_r + SUM_W'(tw);
      end else begin
        src_col_nxt     = '0;
        dst_col_nxt     = '0;
        col_src_sum_nxt = '0;
        col_dst_sum_nxt = '0;
        if (frame_wrap) begin
          src_row_nxt     = '0;
          dst_row_nxt     = '0;
          row_src_sum_nxt = '0;
          row_dst_sum_nxt = '0;
        end else begin
          if (row_hit) begin
            dst_row_nxt     = dst_row_inc;
            row_dst_sum_nxt = row_dst_sum_r + SUM_W'(sh);
          end
          src_row_nxt     = SRC_W'(src_row_inc);
          row_src_sum_nxt = row_src_sum_r + SUM_W'(th);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r       <= ngd_pkg::RST_SOURCE_WIDTH;
      src_h_r       <= ngd_pkg::RST_SOURCE_HEIGHT;
      tgt_w_r       <= ngd_pkg::RST_TARGET_WIDTH;
      tgt_h_r       <= ngd_pkg::RST_TARGET_HEIGHT;
      color_mode_r  <= ngd_pkg::RST_COLOR_MODE;
      src_col_r     <= '0;
      src_row_r     <= '0;
      dst_col_r     <= '0;
      dst_row_r     <= '0;
      col_src_sum_r <= '0;
      col_dst_sum_r <= '0;
      row_src_sum_r <= '0;
      row_dst_sum_r <= '0;
      out_tvalid_r  <= 1'b0;
    end else begin
      if (cfg_acc) begin
        unique case (cfg_index)
          ngd_pkg::REG_SOURCE_WIDTH:  src_w_r      <= cfg_data;
          ngd_pkg::REG_SOURCE_HEIGHT: src_h_r      <= cfg_data;
          ngd_pkg::REG_TARGET_WIDTH:  tgt_w_r      <= cfg_data;
          ngd_pkg::REG_TARGET_HEIGHT: tgt_h_r      <= cfg_data;
          ngd_pkg::REG_COLOR_MODE:    color_mode_r <= cfg_data[0];
          default: ;
        endcase
      end
      src_col_r     <= src_col_nxt;
      src_row_r     <= src_row_nxt;
      dst_col_r     <= dst_col_nxt;
      dst_row_r     <= dst_row_nxt;
      col_src_sum_r <= col_src_sum_nxt;
      col_dst_sum_r <= col_dst_sum_nxt;
      row_src_sum_r <= row_src_sum_nxt;
      row_dst_sum_r <= row_dst_sum_nxt;
      if (in_acc && hit) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && hit) begin
      out_tdata_r <= {ngd_pkg::POS_W'(dst_row_r), ngd_pkg::POS_W'(dst_col_r), luma};
      out_tlast_r <= frame_end;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

endmodule
`default_nettype wire

// ----- rtl/ngd_luma.sv -----
`default_nettype none
module ngd_luma (
  input  wire logic [ngd_pkg::PIX_W-1:0] red,
  input  wire logic [ngd_pkg::PIX_W-1:0] green,
  input  wire logic [ngd_pkg::PIX_W-1:0] blue,
  input  wire logic                      color_mode,
  output logic      [ngd_pkg::PIX_W-1:0] luma
);

  logic [ngd_pkg::LUMA_ACC_W-1:0] prod_r;
  logic [ngd_pkg::LUMA_ACC_W-1:0] prod_g;
  logic [ngd_pkg::LUMA_ACC_W-1:0] prod_b;
  logic [ngd_pkg::LUMA_ACC_W-1:0] acc;

  assign prod_r = ngd_pkg::LUMA_ACC_W'(red)   * ngd_pkg::LUMA_ACC_W'(ngd_pkg::LUMA_COEF_R);
  assign prod_g = ngd_pkg::LUMA_ACC_W'(green) * ngd_pkg::LUMA_ACC_W'(ngd_pkg::LUMA_COEF_G);
  assign prod_b = ngd_pkg::LUMA_ACC_W'(blue)  * ngd_pkg::LUMA_ACC_W'(ngd_pkg::LUMA_COEF_B);
  assign acc    = prod_r + prod_g + prod_b;

  always_comb begin
    case (color_mode)
      ngd_pkg::COLOR_RGB: luma = acc[ngd_pkg::LUMA_ACC_W-1 -: ngd_pkg::PIX_W];
      default:            luma = red;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/ngd_checker.sv -----
`default_nettype none
module ngd_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tready,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [ngd_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic                           out_tlast,
  input wire logic                           cfg_ready
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output changed while stalled");

  a_reset_empty: assert property (@(posedge clk) $rose(rst_n) |-> !out_tvalid)
    else $error("output valid right after reset");

  // With no result waiting the input side is never held off.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with an empty output register");

  // The item after the last one of a frame starts at the first column and row.
  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=>
      !out_tvalid || (out_tdata[19:8] == 12'd0 && out_tdata[31:20] == 12'd0))
    else $error("new frame does not start at the origin");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("configuration port not ready");

endmodule

bind nearest_neighbor_gray_downscaler ngd_checker u_ngd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .cfg_ready  (cfg_ready)
);
`default_nettype wire

// ----- verif/nearest_neighbor_gray_downscaler_test.sv -----
`timescale 1ns / 1ps

module nearest_neighbor_gray_downscaler_test;

  localparam int SETTLE_CYCLES = 4;
  localparam int LONG_HOLD = 400;
  localparam int IDLE_LIMIT = 3000;
  localparam int RANDOM_ITEMS = 650;
  localparam logic [ngd_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  typedef struct packed {
    logic [ngd_pkg::PIX_W-1:0] luma;
    logic [ngd_pkg::POS_W-1:0] col;
    logic [ngd_pkg::POS_W-1:0] row;
    logic frame_end;
  } kept_pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [ngd_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready;
  logic [ngd_pkg::OUT_DATA_W-1:0] out_tdata;
  logic out_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ngd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ngd_pkg::CFG_W-1:0] cfg_data = '0;

  // Shadow copy of the scaler: registers, position counters and running sums.
  logic [ngd_pkg::CFG_W-1:0] src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;
  logic mode_reg;
  logic [31:0] src_x, src_y, dst_x, dst_y;
  logic [31:0] src_x_sum, dst_x_sum, src_y_sum, dst_y_sum;

  kept_pixel_t kept_pixels_q[$];
  int errors = 0;
  int idle_cycles = 0;
  int pixels_sent = 0;
  bit in_gaps_on = 1'b0;
  bit out_gaps_on = 1'b0;
  bit hold_req = 1'b0;

  nearest_neighbor_gray_downscaler i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] fit_dim(input logic [ngd_pkg::CFG_W-1:0] v);
    if (v == 0) return 32'd1;
    if (v > ngd_pkg::MAX_DIM_DEFAULT) return 32'(ngd_pkg::MAX_DIM_DEFAULT);
    return 32'(v);
  endfunction

  function automatic void restart_frame();
    src_x = 0;
    src_y = 0;
    dst_x = 0;
    dst_y = 0;
    src_x_sum = 0;
    dst_x_sum = 0;
    src_y_sum = 0;
    dst_y_sum = 0;
  endfunction

  function automatic void reset_shadow();
    src_w_reg = ngd_pkg::RST_SOURCE_WIDTH;
    src_h_reg = ngd_pkg::RST_SOURCE_HEIGHT;
    dst_w_reg = ngd_pkg::RST_TARGET_WIDTH;
    dst_h_reg = ngd_pkg::RST_TARGET_HEIGHT;
    mode_reg = ngd_pkg::RST_COLOR_MODE;
    restart_frame();
  endfunction

  function automatic void shadow_write(input logic [ngd_pkg::CFG_IDX_W-1:0] idx,
                                       input logic [ngd_pkg::CFG_W-1:0] data);
    case (idx)
      ngd_pkg::REG_SOURCE_WIDTH: src_w_reg = data;
      ngd_pkg::REG_SOURCE_HEIGHT: src_h_reg = data;
      ngd_pkg::REG_TARGET_WIDTH: dst_w_reg = data;
      ngd_pkg::REG_TARGET_HEIGHT: dst_h_reg = data;
      ngd_pkg::REG_COLOR_MODE: mode_reg = data[0];
      default: return;
    endcase
    restart_frame();
  endfunction

  function automatic void scale_pixel(input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b);
    logic [31:0] sw, sh, tw, th, y;
    logic col_hit, row_hit;
    kept_pixel_t px;
    sw = fit_dim(src_w_reg);
    sh = fit_dim(src_h_reg);
    tw = fit_dim(dst_w_reg);
    th = fit_dim(dst_h_reg);
    if (tw > sw) tw = sw;
    if (th > sh) th = sh;
    col_hit = (dst_x < tw) && (dst_x_sum < src_x_sum + tw);
    row_hit = (dst_y < th) && (dst_y_sum < src_y_sum + th);
    if (col_hit && row_hit) begin
      if (mode_reg == ngd_pkg::COLOR_RGB) begin
        y = (32'd19595 * r + 32'd38470 * g + 32'd7471 * b) >> 16;
      end else begin
        y = {24'd0, r};
      end
      px.luma = y[7:0];
      px.col = dst_x[ngd_pkg::POS_W-1:0];
      px.row = dst_y[ngd_pkg::POS_W-1:0];
      px.frame_end = (dst_x + 1 == tw) && (dst_y + 1 == th);
      kept_pixels_q.push_back(px);
      dst_x = dst_x + 1;
      dst_x_sum = dst_x_sum + sw;
    end
    if (src_x + 1 < sw) begin
      src_x = src_x + 1;
      src_x_sum = src_x_sum + tw;
      return;
    end
    src_x = 0;
    dst_x = 0;
    src_x_sum = 0;
    dst_x_sum = 0;
    if (src_y + 1 >= sh) begin
      restart_frame();
      return;
    end
    if (row_hit) begin
      dst_y = dst_y + 1;
      dst_y_sum = dst_y_sum + sh;
    end
    src_y = src_y + 1;
    src_y_sum = src_y_sum + th;
  endfunction

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    int gap;
    gap = in_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {b, g, r};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    scale_pixel(r, g, b);
    pixels_sent++;
  endtask

  task automatic send_random_pixel();
    logic [7:0] r, g, b;
    if ($urandom_range(0, 7) == 0) begin
      r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    end else begin
      r = 8'($urandom);
      g = 8'($urandom);
      b = 8'($urandom);
    end
    send_pixel(r, g, b);
  endtask

  // Stop the input and wait until every kept pixel has come out.
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (kept_pixels_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ngd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ngd_pkg::CFG_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    shadow_write(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_sizes(input logic [ngd_pkg::CFG_W-1:0] sw,
                             input logic [ngd_pkg::CFG_W-1:0] sh,
                             input logic [ngd_pkg::CFG_W-1:0] tw,
                             input logic [ngd_pkg::CFG_W-1:0] th);
    write_reg(ngd_pkg::REG_SOURCE_WIDTH, sw);
    write_reg(ngd_pkg::REG_SOURCE_HEIGHT, sh);
    write_reg(ngd_pkg::REG_TARGET_WIDTH, tw);
    write_reg(ngd_pkg::REG_TARGET_HEIGHT, th);
  endtask

  task automatic test_defaults();
    int k;
    for (k = 0; k < 10; k++) begin
      send_pixel(k[0] ? 8'hFF : 8'h00, k[1] ? 8'hFF : 8'h00, k[2] ? 8'hFF : 8'h00);
    end
    settle();
  endtask

  task automatic test_gray_wrap();
    int k;
    write_reg(ngd_pkg::REG_COLOR_MODE, {12'd0, ngd_pkg::COLOR_GRAY});
    write_sizes(13'd3, 13'd2, 13'd2, 13'd1);
    for (k = 0; k < 8; k++) send_pixel(8'(8'hFF - k * 8'h25), 8'hA5, 8'h5A);
    settle();
  endtask

  task automatic test_size_limits();
    int k;
    write_reg(ngd_pkg::REG_COLOR_MODE, {12'd0, ngd_pkg::COLOR_RGB});
    write_sizes(13'd0, 13'd0, 13'd0, 13'd0);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'h80, 8'h01, 8'hFE);
    settle();
    write_sizes(13'd3, 13'd1, 13'd7, 13'd0);
    for (k = 0; k < 3; k++) send_pixel(8'(8'h10 * k), 8'hFF, 8'h00);
    settle();
    write_sizes(13'd8191, 13'd1, 13'd5000, 13'd1);
    for (k = 0; k < 4; k++) send_pixel(8'h00, 8'(8'h40 * k), 8'hFF);
    settle();
    write_sizes(13'd1, 13'd4096, 13'd1, 13'd8191);
    for (k = 0; k < 4; k++) send_pixel(8'h33, 8'h77, 8'(8'h11 * k));
    settle();
    // An unmapped index must leave both the sizes and the frame position alone.
    write_reg(REG_UNMAPPED, 13'h1FFF);
    for (k = 0; k < 3; k++) send_pixel(8'hC0, 8'h0C, 8'h3F);
    settle();
  endtask

  task automatic test_backpressure();
    int k;
    in_gaps_on = 1'b0;
    out_gaps_on = 1'b0;
    write_reg(ngd_pkg::REG_COLOR_MODE, {12'd0, ngd_pkg::COLOR_RGB});
    write_sizes(13'd8, 13'd4, 13'd8, 13'd4);
    hold_req = 1'b1;
    for (k = 0; k < 40; k++) send_random_pixel();
    settle();
    write_sizes(13'd8, 13'd4, 13'd3, 13'd2);
    hold_req = 1'b1;
    for (k = 0; k < 40; k++) send_random_pixel();
    settle();
  endtask

  function automatic logic [ngd_pkg::CFG_W-1:0] pick_size(input int top);
    int roll;
    roll = $urandom_range(0, 11);
    if (roll == 0) return '0;
    if (roll == 1) return ngd_pkg::CFG_W'($urandom_range(4097, 8191));
    return ngd_pkg::CFG_W'($urandom_range(1, top));
  endfunction

  task automatic test_random_frames();
    logic [ngd_pkg::CFG_W-1:0] sw, sh;
    int count, k;
    bit first;
    first = 1'b1;
    while (pixels_sent < RANDOM_ITEMS - 40) begin
      in_gaps_on = ($urandom_range(0, 3) != 0);
      out_gaps_on = ($urandom_range(0, 3) != 0);
      if (first || $urandom_range(0, 3) != 0) begin
        write_sizes(pick_size(16), pick_size(12), pick_size(20), pick_size(14));
      end else if ($urandom_range(0, 1) == 0) begin
        write_reg(ngd_pkg::CFG_IDX_W'($urandom_range(ngd_pkg::REG_SOURCE_WIDTH,
                                                     ngd_pkg::REG_TARGET_HEIGHT)),
                  pick_size(16));
      end
      if (first || $urandom_range(0, 1) == 0) begin
        write_reg(ngd_pkg::REG_COLOR_MODE, {12'd0, 1'($urandom_range(0, 1))});
      end
      first = 1'b0;
      sw = src_w_reg;
      sh = src_h_reg;
      count = fit_dim(sw) * fit_dim(sh) * $urandom_range(1, 3);
      if (count > 90) count = $urandom_range(20, 90);
      if ($urandom_range(0, 4) == 0) count = $urandom_range(1, count);
      for (k = 0; k < count; k++) send_random_pixel();
      settle();
    end
  endtask

  initial begin
    out_tready = 1'b0;
    forever begin : receiver
      int hold_left, stall_left;
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (out_gaps_on && $urandom_range(0, 2) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    kept_pixel_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (kept_pixels_q.size() == 0) begin
        errors++;
        $display("%0t: pixel expected none actual data=%h last=%b", $time, out_tdata,
                 out_tlast);
      end else begin
        want = kept_pixels_q.pop_front();
        if (out_tdata[7:0] !== want.luma) begin
          errors++;
          $display("%0t: luma expected %0d actual %0d", $time, want.luma, out_tdata[7:0]);
        end
        if (out_tdata[19:8] !== want.col) begin
          errors++;
          $display("%0t: column expected %0d actual %0d", $time, want.col, out_tdata[19:8]);
        end
        if (out_tdata[31:20] !== want.row) begin
          errors++;
          $display("%0t: row expected %0d actual %0d", $time, want.row, out_tdata[31:20]);
        end
        if (out_tlast !== want.frame_end) begin
          errors++;
          $display("%0t: frame end expected %b actual %b", $time, want.frame_end, out_tlast);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
      $display("nearest_neighbor_gray_downscaler test failed");
      $finish;
    end
  end

  initial begin
    reset_shadow();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    in_gaps_on = 1'b1;
    out_gaps_on = 1'b1;
    test_defaults();
    test_gray_wrap();
    test_size_limits();
    test_backpressure();
    test_random_frames();
    settle();
    if (errors == 0 && kept_pixels_q.size() == 0) begin
      $display("nearest_neighbor_gray_downscaler test passed");
    end else begin
      $display("nearest_neighbor_gray_downscaler test failed");
    end
    $finish;
  end

endmodule
